### sv/mie_pkg.sv
package mie_pkg;

  typedef logic [31:0] word_t;
  typedef logic [25:0] pc_t;
  typedef logic [4:0]  reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OVF     = 3'd1,
    ST_TRAP    = 3'd2,
    ST_BREAK   = 3'd3,
    ST_SYSCALL = 3'd4,
    ST_DIVZERO = 3'd5,
    ST_UNSUP   = 3'd6,
    ST_END     = 3'd7
  } status_t;

  // class of work the back end has to run for a word
  typedef enum logic [2:0] {
    CL_SIMPLE,
    CL_MUL,
    CL_DIV,
    CL_CLZ,
    CL_FAULT
  } class_t;

  typedef struct packed {
    word_t   instr;
    class_t  cls;
    status_t fault;
  } dec_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EXEC,
    BS_MUL,
    BS_DIV,
    BS_DFIX,
    BS_CLZ,
    BS_DONE
  } bstate_t;

  // major opcodes
  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_REGIMM   = 6'h01;
  localparam logic [5:0] OP_J        = 6'h02;
  localparam logic [5:0] OP_JAL      = 6'h03;
  localparam logic [5:0] OP_BEQ      = 6'h04;
  localparam logic [5:0] OP_BNE      = 6'h05;
  localparam logic [5:0] OP_BLEZ     = 6'h06;
  localparam logic [5:0] OP_BGTZ     = 6'h07;
  localparam logic [5:0] OP_ADDI     = 6'h08;
  localparam logic [5:0] OP_ADDIU    = 6'h09;
  localparam logic [5:0] OP_SLTI     = 6'h0A;
  localparam logic [5:0] OP_SLTIU    = 6'h0B;
  localparam logic [5:0] OP_ANDI     = 6'h0C;
  localparam logic [5:0] OP_ORI      = 6'h0D;
  localparam logic [5:0] OP_XORI     = 6'h0E;
  localparam logic [5:0] OP_LUI      = 6'h0F;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;

  // SPECIAL functs
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;
  localparam logic [5:0] FN_TGE     = 6'd48;
  localparam logic [5:0] FN_TGEU    = 6'd49;
  localparam logic [5:0] FN_TLT     = 6'd50;
  localparam logic [5:0] FN_TLTU    = 6'd51;
  localparam logic [5:0] FN_TEQ     = 6'd52;
  localparam logic [5:0] FN_TNE     = 6'd54;

  // SPECIAL2 functs
  localparam logic [5:0] F2_MADD  = 6'd0;
  localparam logic [5:0] F2_MADDU = 6'd1;
  localparam logic [5:0] F2_MUL   = 6'd2;
  localparam logic [5:0] F2_MSUB  = 6'd4;
  localparam logic [5:0] F2_MSUBU = 6'd5;
  localparam logic [5:0] F2_CLZ   = 6'd32;
  localparam logic [5:0] F2_CLO   = 6'd33;

  localparam word_t    GP_RESET = 32'h0050_0000;
  localparam word_t    SP_RESET = 32'h00A0_0000;
  localparam reg_idx_t REG_GP   = 5'd28;
  localparam reg_idx_t REG_SP   = 5'd29;
  localparam reg_idx_t REG_RA   = 5'd31;

  localparam logic CFG_GP = 1'b0;
  localparam logic CFG_SP = 1'b1;

  // leading zeros of one byte, 8 for zero
  function automatic logic [3:0] lz8(input logic [7:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

### sv/mie_front.sv
module mie_front import mie_pkg::*; (
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t instruction,
  input  logic  q_full,
  output logic  q_push,
  output dec_t  q_data
);

  logic [5:0] op, fn;
  logic [4:0] rt;

  assign op = instruction[31:26];
  assign rt = instruction[20:16];
  assign fn = instruction[5:0];

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.instr = instruction;
    q_data.cls   = CL_SIMPLE;
    q_data.fault = ST_OK;
    if (instruction == '0) begin
      q_data.cls   = CL_FAULT;
      q_data.fault = ST_END;
    end else if (op == OP_SPECIAL) begin
      unique case (fn)
        FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
        FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
        FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU, FN_TGE, FN_TGEU,
        FN_TLT, FN_TLTU, FN_TEQ, FN_TNE: q_data.cls = CL_SIMPLE;
        FN_MULT, FN_MULTU: q_data.cls = CL_MUL;
        FN_DIV, FN_DIVU:   q_data.cls = CL_DIV;
        FN_SYSCALL: begin
          q_data.cls   = CL_FAULT;
          q_data.fault = ST_SYSCALL;
        end
        FN_BREAK: begin
          q_data.cls   = CL_FAULT;
          q_data.fault = ST_BREAK;
        end
        default: begin
          q_data.cls   = CL_FAULT;
          q_data.fault = ST_UNSUP;
        end
      endcase
    end else if (op == OP_SPECIAL2) begin
      unique case (fn)
        F2_MADD, F2_MADDU, F2_MUL, F2_MSUB, F2_MSUBU: q_data.cls = CL_MUL;
        F2_CLZ, F2_CLO: q_data.cls = CL_CLZ;
        default: begin
          q_data.cls   = CL_FAULT;
          q_data.fault = ST_UNSUP;
        end
      endcase
    end else if (op == OP_REGIMM) begin
      if (rt > 5'd1) begin
        q_data.cls   = CL_FAULT;
        q_data.fault = ST_UNSUP;
      end
    end else if (op > OP_LUI) begin
      q_data.cls   = CL_FAULT;
      q_data.fault = ST_UNSUP;
    end
  end

endmodule

### sv/mie_queue.sv
module mie_queue import mie_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  dec_t push_data,
  input  logic pop,
  output dec_t head,
  output logic not_empty,
  output logic full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dec_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### sv/mie_back.sv
module mie_back import mie_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  dec_t     q_head,
  output logic     q_pop,
  input  logic     cfg_write,
  input  logic     cfg_index,
  input  word_t    cfg_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pc_t      next_pc,
  output status_t  status,
  output logic     write_enable,
  output reg_idx_t write_index,
  output word_t    write_value,
  output word_t    hi_value,
  output word_t    lo_value
);

  typedef struct packed {
    pc_t      next;
    status_t  st;
    logic     we;
    reg_idx_t wi;
    word_t    wv;
    word_t    hi;
    word_t    lo;
  } res_t;

  bstate_t state, state_next;

  // architectural state
  word_t       mem [32];
  logic [31:0] valid;
  word_t       gp, sp, hi, lo;
  pc_t         pc;

  // working registers
  dec_t        d;
  word_t       a, b;
  res_t        res, res_c;
  logic        res_load;
  logic [63:0] prod;
  logic        mul_acc, mul_sub;
  word_t       quo, rem, dvs;
  logic [4:0]  dcnt;
  word_t       cval;
  logic [5:0]  ccnt;
  logic [1:0]  cstep;

  logic [5:0]  op, fn;
  reg_idx_t    rt, rd;
  logic [4:0]  sh;
  word_t       imm, simm;
  pc_t         pc1, target;
  logic        commit, fault;

  assign op     = d.instr[31:26];
  assign rt     = d.instr[20:16];
  assign rd     = d.instr[15:11];
  assign sh     = d.instr[10:6];
  assign fn     = d.instr[5:0];
  assign imm    = {16'h0000, d.instr[15:0]};
  assign simm   = {{16{d.instr[15]}}, d.instr[15:0]};
  assign pc1    = pc + 1'b1;
  assign target = pc1 + simm[25:0];

  assign commit = (state == BS_DONE) && (!out_valid || !out_stall);
  assign fault  = res.st != ST_OK;
  assign q_pop  = (state == BS_IDLE) && q_valid;

  function automatic word_t reg_read(input reg_idx_t i, input logic [31:0] vld,
                                     input word_t m, input word_t g, input word_t s);
    word_t v;
    if (vld[i])           v = m;
    else if (i == REG_GP) v = g;
    else if (i == REG_SP) v = s;
    else                  v = '0;
    return v;
  endfunction

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= BS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: if (q_valid) state_next = BS_EXEC;
      BS_EXEC: begin
        unique case (d.cls)
          CL_MUL:  state_next = BS_MUL;
          CL_DIV:  state_next = (b == '0) ? BS_DONE : BS_DIV;
          CL_CLZ:  state_next = BS_CLZ;
          default: state_next = BS_DONE;
        endcase
      end
      BS_MUL:  state_next = BS_DONE;
      BS_DIV:  if (dcnt == 5'd31) state_next = BS_DFIX;
      BS_DFIX: state_next = BS_DONE;
      BS_CLZ:  if (cval[31:24] != '0 || cstep == 2'd3) state_next = BS_DONE;
      BS_DONE: if (commit) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  // result of the current word
  always_comb begin
    logic [31:0] r;
    logic        slt, sltu;
    logic [63:0] base, addend, sum;
    r            = '0;
    slt          = $signed(a) < $signed(b);
    sltu         = a < b;
    base         = mul_acc ? {hi, lo} : 64'd0;
    addend       = mul_sub ? ~prod : prod;
    sum          = base + addend + {63'd0, mul_sub};
    res_c        = '{next: pc1, st: ST_OK, we: 1'b0, wi: '0, wv: '0, hi: hi, lo: lo};
    res_load     = 1'b0;
    unique case (state)
      BS_EXEC: begin
        res_load = (d.cls == CL_SIMPLE) || (d.cls == CL_FAULT) ||
                   (d.cls == CL_DIV && b == '0);
        if (d.cls == CL_FAULT) begin
          res_c.st = d.fault;
        end else if (d.cls == CL_DIV) begin
          res_c.st = ST_DIVZERO;
        end else if (op == OP_SPECIAL) begin
          res_c.wi = rd;
          res_c.we = 1'b1;
          unique case (fn)
            FN_SLL:  res_c.wv = b << sh;
            FN_SRL:  res_c.wv = b >> sh;
            FN_SRA:  res_c.wv = word_t'($signed(b) >>> sh);
            FN_SLLV: res_c.wv = b << a[4:0];
            FN_SRLV: res_c.wv = b >> a[4:0];
            FN_SRAV: res_c.wv = word_t'($signed(b) >>> a[4:0]);
            FN_JR: begin
              res_c.we   = 1'b0;
              res_c.next = a[25:0];
            end
            FN_JALR: begin
              res_c.next = a[25:0];
              res_c.wv   = {6'd0, pc1};
            end
            FN_MFHI: res_c.wv = hi;
            FN_MFLO: res_c.wv = lo;
            FN_MTHI: begin
              res_c.we = 1'b0;
              res_c.hi = a;
            end
            FN_MTLO: begin
              res_c.we = 1'b0;
              res_c.lo = a;
            end
            FN_ADD: begin
              r        = a + b;
              res_c.wv = r;
              if (((a ^ r) & (b ^ r)) >> 31 != 0) res_c.st = ST_OVF;
            end
            FN_ADDU: res_c.wv = a + b;
            FN_SUB: begin
              r        = a - b;
              res_c.wv = r;
              if (((a ^ b) & (a ^ r)) >> 31 != 0) res_c.st = ST_OVF;
            end
            FN_SUBU: res_c.wv = a - b;
            FN_AND:  res_c.wv = a & b;
            FN_OR:   res_c.wv = a | b;
            FN_XOR:  res_c.wv = a ^ b;
            FN_NOR:  res_c.wv = ~(a | b);
            FN_SLT:  res_c.wv = {31'd0, slt};
            FN_SLTU: res_c.wv = {31'd0, sltu};
            default: begin
              // traps
              res_c.we = 1'b0;
              unique case (fn)
                FN_TGE:  if (!slt)   res_c.st = ST_TRAP;
                FN_TGEU: if (!sltu)  res_c.st = ST_TRAP;
                FN_TLT:  if (slt)    res_c.st = ST_TRAP;
                FN_TLTU: if (sltu)   res_c.st = ST_TRAP;
                FN_TEQ:  if (a == b) res_c.st = ST_TRAP;
                FN_TNE:  if (a != b) res_c.st = ST_TRAP;
                default: res_c.st = ST_UNSUP;
              endcase
            end
          endcase
        end else begin
          res_c.wi = rt;
          res_c.we = 1'b1;
          unique case (op)
            OP_REGIMM: begin
              res_c.we = 1'b0;
              if (a[31] != rt[0]) res_c.next = target;
            end
            OP_J: begin
              res_c.we   = 1'b0;
              res_c.next = d.instr[25:0];
            end
            OP_JAL: begin
              res_c.next = d.instr[25:0];
              res_c.wi   = REG_RA;
              res_c.wv   = {6'd0, pc1};
            end
            OP_BEQ: begin
              res_c.we = 1'b0;
              if (a == b) res_c.next = target;
            end
            OP_BNE: begin
              res_c.we = 1'b0;
              if (a != b) res_c.next = target;
            end
            OP_BLEZ: begin
              res_c.we = 1'b0;
              if (a[31] || a == '0) res_c.next = target;
            end
            OP_BGTZ: begin
              res_c.we = 1'b0;
              if (!a[31] && a != '0) res_c.next = target;
            end
            OP_ADDI: begin
              r        = a + simm;
              res_c.wv = r;
              if (((a ^ r) & (simm ^ r)) >> 31 != 0) res_c.st = ST_OVF;
            end
            OP_ADDIU: res_c.wv = a + simm;
            OP_SLTI:  res_c.wv = {31'd0, $signed(a) < $signed(simm)};
            OP_SLTIU: res_c.wv = {31'd0, a < simm};
            OP_ANDI:  res_c.wv = a & imm;
            OP_ORI:   res_c.wv = a | imm;
            OP_XORI:  res_c.wv = a ^ imm;
            OP_LUI:   res_c.wv = {d.instr[15:0], 16'h0000};
            default: begin
              res_c.we = 1'b0;
              res_c.st = ST_UNSUP;
            end
          endcase
        end
      end
      BS_MUL: begin
        res_load = 1'b1;
        if (op == OP_SPECIAL2 && fn == F2_MUL) begin
          res_c.we = 1'b1;
          res_c.wi = rd;
          res_c.wv = sum[31:0];
        end else begin
          res_c.hi = sum[63:32];
          res_c.lo = sum[31:0];
        end
      end
      BS_DFIX: begin
        res_load = 1'b1;
        res_c.lo = (fn == FN_DIV && (a[31] ^ b[31])) ? 32'd0 - quo : quo;
        res_c.hi = (fn == FN_DIV && a[31]) ? 32'd0 - rem : rem;
      end
      BS_CLZ: begin
        res_load = (cval[31:24] != '0) || (cstep == 2'd3);
        res_c.we = 1'b1;
        res_c.wi = rd;
        res_c.wv = {26'd0, ccnt + 6'(lz8(cval[31:24]))};
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [32:0] shl, diff;
    logic        sgn;
    word_t       ma, mb;
    shl  = {rem, quo[31]};
    diff = shl - {1'b0, dvs};
    sgn  = (op == OP_SPECIAL) ? (fn == FN_MULT || fn == FN_DIV)
                              : (fn == F2_MADD || fn == F2_MSUB || fn == F2_MUL);
    ma   = (sgn && a[31]) ? 32'd0 - a : a;
    mb   = (sgn && b[31]) ? 32'd0 - b : b;

    if (q_pop) begin
      d <= q_head;
      a <= reg_read(q_head.instr[25:21], valid, mem[q_head.instr[25:21]], gp, sp);
      b <= reg_read(q_head.instr[20:16], valid, mem[q_head.instr[20:16]], gp, sp);
    end

    if (state == BS_EXEC) begin
      prod    <= ma * mb;
      mul_acc <= (op == OP_SPECIAL2) && (fn != F2_MUL);
      mul_sub <= (sgn && (a[31] ^ b[31])) ^
                 ((op == OP_SPECIAL2) && (fn == F2_MSUB || fn == F2_MSUBU));
      quo     <= ma;
      dvs     <= mb;
      rem     <= '0;
      dcnt    <= '0;
      cval    <= (fn == F2_CLO) ? ~a : a;
      ccnt    <= '0;
      cstep   <= '0;
    end

    if (state == BS_DIV) begin
      dcnt <= dcnt + 1'b1;
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shl[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end

    if (state == BS_CLZ && cval[31:24] == '0) begin
      ccnt  <= ccnt + 6'd8;
      cval  <= cval << 8;
      cstep <= cstep + 1'b1;
    end

    if (res_load) res <= res_c;

    if (commit && !fault && res.we && res.wi != '0) mem[res.wi] <= res.wv;
  end

  // architectural control state and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      gp        <= GP_RESET;
      sp        <= SP_RESET;
      hi        <= '0;
      lo        <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit)                  out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      // config writes must only come while the core is idle; not enforced here
      if (cfg_write) begin
        if (cfg_index == CFG_GP) begin
          gp            <= cfg_data;
          valid[REG_GP] <= 1'b0;
        end else begin
          sp            <= cfg_data;
          valid[REG_SP] <= 1'b0;
        end
      end else if (commit) begin
        status    <= res.st;
        if (fault) begin
          next_pc      <= pc;
          write_enable <= 1'b0;
          write_index  <= '0;
          write_value  <= '0;
          hi_value     <= hi;
          lo_value     <= lo;
        end else begin
          pc           <= res.next;
          hi           <= res.hi;
          lo           <= res.lo;
          next_pc      <= res.next;
          hi_value     <= res.hi;
          lo_value     <= res.lo;
          if (res.we && res.wi != '0) begin
            valid[res.wi] <= 1'b1;
            write_enable  <= 1'b1;
            write_index   <= res.wi;
            write_value   <= res.wv;
          end else begin
            write_enable <= 1'b0;
            write_index  <= '0;
            write_value  <= '0;
          end
        end
      end
    end
  end

endmodule

### sv/mips32_integer_execute.sv
// MIPS32 integer execute core. Each input word is one instruction, taken as
// the one fetched at the current program counter; each yields exactly one
// result word: next pc (word index), status, the general-register write and
// HI/LO afterwards. Faults (overflow, trap, break, syscall, divide by zero,
// unsupported, end on word 0) leave all state untouched and report the
// current pc. Words go through a decoder into a short queue, so the input
// side keeps taking words while the execution sequencer is busy or the
// output word is stalled, until the queue fills. ALU, branch, jump, trap
// and fault words pass EXEC and DONE; mult/multu, madd/msub and mul add MUL
// (one 32x32 multiply, then a 64-bit sign-fix/accumulate); clz/clo add CLZ
// (one byte scanned per cycle); div/divu add DIV (one quotient bit per
// cycle) and DFIX. A word waits in DONE while the previous output word is
// stalled. The register file is a 32-entry memory with two registered read
// ports; after reset r0..r31 read zero except r28/r29 (gp/sp init values).
// Writing config register 0 (gp init) or 1 (sp init) loads r28 or r29 at
// once; it is to be done only while the core is idle, which is not enforced.
module mips32_integer_execute import mie_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // instruction channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [25:0] next_pc,
  output logic [2:0]  status,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [31:0] write_value,
  output logic [31:0] hi_value,
  output logic [31:0] lo_value
);

  dec_t    push_data, head;
  logic    push, pop, not_empty, full;
  status_t st;

  // decode and classify
  mie_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .instruction (instruction),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  // decoupling queue
  mie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  // execution sequencer and architectural state
  mie_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (not_empty),
    .q_head       (head),
    .q_pop        (pop),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_pc      (next_pc),
    .status       (st),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_value  (write_value),
    .hi_value     (hi_value),
    .lo_value     (lo_value)
  );

  assign status = st;

endmodule

### sv/mie_checker.sv
module mie_checker import mie_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [25:0] next_pc,
  input logic [2:0]  status,
  input logic        write_enable,
  input logic [4:0]  write_index,
  input logic [31:0] write_value
);

  // nothing left over from before reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(status)
                               && $stable(write_value))
    else $error("stalled result word changed");

  // a faulting word never writes a register
  a_fault_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !write_enable)
    else $error("register write reported with a fault status");

  // r0 never shows as written
  a_r0: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> write_index != 5'd0)
    else $error("write to r0 reported");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_index == 5'd0 && write_value == 32'd0)
    else $error("write index or value not zero without a write");

endmodule

bind mips32_integer_execute mie_checker u_mie_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .next_pc      (next_pc),
  .status       (status),
  .write_enable (write_enable),
  .write_index  (write_index),
  .write_value  (write_value)
);
